[rtl/bds_pkg.sv]
// ----------------------------------------------------------------------------
// bds_pkg
// Shared widths, divider tables and divider handshake types for the baud
// divider search block.
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

    localparam int unsigned RateW  = 28;  // clock and target width
    localparam int unsigned AchW   = 26;  // achieved rate width
    localparam int unsigned DivW   = 18;  // scaler * prescaler, up to 229376
    localparam int unsigned PreW   = 2;
    localparam int unsigned ScalW  = 4;
    localparam int unsigned CandW  = PreW + ScalW;

    localparam logic [RateW-1:0] ClockReset = 28'd100000000;

    // Request into the shared divider
    typedef struct packed {
        logic             start;
        logic [RateW-1:0] dividend;
        logic [DivW-1:0]  divisor;
    } t_div_req;

    // Response from the shared divider
    typedef struct packed {
        logic             done;
        logic [RateW-1:0] quotient;
    } t_div_rsp;

    // Prescaler table: 2, 3, 5, 7
    function automatic logic [2:0] presc_val(input logic [PreW-1:0] idx);
        logic [2:0] val;
        case (idx)
            2'd0:    val = 3'd2;
            2'd1:    val = 3'd3;
            2'd2:    val = 3'd5;
            default: val = 3'd7;
        endcase
        return val;
    endfunction

    // Scaler table: 2, 4, 6, 8, then 16 doubling to 32768
    function automatic logic [15:0] scal_val(input logic [ScalW-1:0] idx);
        logic [15:0] val;
        case (idx)
            4'd0:    val = 16'd2;
            4'd1:    val = 16'd4;
            4'd2:    val = 16'd6;
            4'd3:    val = 16'd8;
            default: val = 16'd1 << idx;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[rtl/bds_div.sv]
// ----------------------------------------------------------------------------
// bds_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  bds_pkg::t_div_req   i_req,
    output bds_pkg::t_div_rsp   o_rsp
);
    import bds_pkg::*;

    localparam int unsigned CntW = $clog2(RateW);

    logic               r_busy;
    logic               r_done;
    logic [CntW-1:0]    r_cnt;
    logic [RateW-1:0]   r_quo;
    logic [DivW-1:0]    r_rem;
    logic [DivW-1:0]    r_div;

    logic [DivW:0]      shifted;
    logic [DivW:0]      diff;
    logic               q_bit;

    // Trial subtraction of the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_quo[RateW-1]};
        diff    = shifted - {1'b0, r_div};
        q_bit   = (shifted >= {1'b0, r_div});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(RateW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top, quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[RateW-2:0], q_bit};
            r_rem <= q_bit ? diff[DivW-1:0] : shifted[DivW-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

[rtl/baud_divider_search.sv]
// ----------------------------------------------------------------------------
// baud_divider_search
// Searches all 64 prescaler/scaler pairs for the rate closest to a target.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_target_rate
// result    out        o_valid / i_stall     o_prescaler_index, o_scaler_index,
//                                            o_achieved_rate, o_rate_error
// config    in         i_cfg_we              i_cfg_data (clock_hz)
//
// For each candidate the sequencer issues a division to the shared bit-serial
// divider, waits for its result and compares it with the best so far. o_valid
// rises when the finish state posts the best pair; the sequencer then returns
// to idle, where the next input may be accepted. The input is stalled for the
// whole search; a new transaction may enter while a result still waits on a
// stalled output, and its search then holds at the end until the output slot
// frees. Synchronous active-low reset sets clock_hz to 100000000 and clears all
// handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module baud_divider_search (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [bds_pkg::RateW-1:0]     i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [bds_pkg::RateW-1:0]     i_target_rate,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [bds_pkg::PreW-1:0]     o_prescaler_index,
    output logic [bds_pkg::ScalW-1:0]    o_scaler_index,
    output logic [bds_pkg::AchW-1:0]     o_achieved_rate,
    output logic [bds_pkg::RateW-1:0]    o_rate_error
);
    import bds_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [RateW-1:0]   r_clock_hz;
    logic [RateW-1:0]   r_target;
    logic [CandW-1:0]   r_cand;
    logic [AchW-1:0]    r_best_rate;
    logic [RateW-1:0]   r_best_err;
    logic [CandW-1:0]   r_best_cand;

    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic [AchW-1:0]    cand_rate;
    logic [RateW-1:0]   cand_err;
    logic               take;
    logic [DivW-1:0]    divisor_full;

    // Divisor for the current pair
    always_comb begin
        divisor_full     = DivW'(scal_val(r_cand[ScalW-1:0])) *
                           DivW'(presc_val(r_cand[CandW-1:ScalW]));
        div_req.start    = (r_state == S_ISSUE);
        div_req.dividend = r_clock_hz;
        div_req.divisor  = divisor_full;
    end

    bds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Candidate error and replace decision
    always_comb begin
        cand_rate = div_rsp.quotient[AchW-1:0];
        if (r_target < RateW'(cand_rate)) begin
            cand_err = RateW'(cand_rate) - r_target;
        end else begin
            cand_err = r_target - RateW'(cand_rate);
        end
        take = (r_best_rate == '0) || (cand_err < r_best_err);
    end

    assign o_stall = (r_state != S_IDLE);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= ClockReset;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_data;
        end
    end

    // Sequencer, best-so-far and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            // Result taken; the finish state reloads the slot itself
            if (o_valid && !i_stall && (r_state != S_FINISH)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_target    <= i_target_rate;
                        r_cand      <= '0;
                        r_best_rate <= '0;
                        r_best_err  <= '0;
                        r_best_cand <= '0;
                        r_state     <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_rsp.done) begin
                        if (take) begin
                            r_best_rate <= cand_rate;
                            r_best_err  <= cand_err;
                            r_best_cand <= r_cand;
                        end
                        if (r_cand == '1) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_cand  <= r_cand + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_FINISH: begin
                    if (!o_valid || !i_stall) begin
                        o_valid           <= 1'b1;
                        o_prescaler_index <= r_best_cand[CandW-1:ScalW];
                        o_scaler_index    <= r_best_cand[ScalW-1:0];
                        o_achieved_rate   <= r_best_rate;
                        o_rate_error      <= r_best_err;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/bds_checker.sv]
// ----------------------------------------------------------------------------
// bds_checker
// Port-level checks for the baud divider search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bds_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_valid,
    input wire                         o_stall,
    input wire                         o_valid,
    input wire                         i_stall,
    input wire [bds_pkg::PreW-1:0]     o_prescaler_index,
    input wire [bds_pkg::ScalW-1:0]    o_scaler_index,
    input wire [bds_pkg::AchW-1:0]     o_achieved_rate,
    input wire [bds_pkg::RateW-1:0]    o_rate_error
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_achieved_rate) &&
        $stable(o_rate_error) && $stable(o_prescaler_index) &&
        $stable(o_scaler_index))
        else $error("stalled result changed");

    // An accepted input starts a search, which stalls the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // A result only appears at the end of a search
    a_result_from_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a search");

    // Reset drops the result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind baud_divider_search bds_checker u_bds_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_prescaler_index (o_prescaler_index),
    .o_scaler_index    (o_scaler_index),
    .o_achieved_rate   (o_achieved_rate),
    .o_rate_error      (o_rate_error)
);

`default_nettype wire
